/* src/lobm_pkg.sv */
// ----------------------------------------------------------------------------
// lobm_pkg
// Types and constants shared by the order book cells and the top level.
// ----------------------------------------------------------------------------
package lobm_pkg;

    localparam int IDX_W   = 6;   // slot index, up to 64 slots
    localparam int CNT_W   = 7;   // sweep counter, holds slot count + 1
    localparam int AVAIL_W = 38;  // sum of up to 64 quantities of 32 bits

    localparam logic [1:0] KIND_ADD    = 2'd0;
    localparam logic [1:0] KIND_CANCEL = 2'd1;
    localparam logic [1:0] KIND_MODIFY = 2'd2;
    localparam logic [1:0] KIND_NONE   = 2'd3;

    localparam logic [1:0] TIF_GTC = 2'd0;
    localparam logic [1:0] TIF_FOK = 2'd2;

    localparam logic [2:0] ST_NEW       = 3'd0;
    localparam logic [2:0] ST_PARTIAL   = 3'd1;
    localparam logic [2:0] ST_FILLED    = 3'd2;
    localparam logic [2:0] ST_CANCELLED = 3'd3;
    localparam logic [2:0] ST_REJECTED  = 3'd4;

    localparam logic [2:0] REJ_NONE     = 3'd0;
    localparam logic [2:0] REJ_UNKNOWN  = 3'd1;
    localparam logic [2:0] REJ_DUP      = 3'd2;
    localparam logic [2:0] REJ_BAD_QTY  = 3'd3;
    localparam logic [2:0] REJ_BAD_PX   = 3'd4;
    localparam logic [2:0] REJ_NO_LIQ   = 3'd5;
    localparam logic [2:0] REJ_FOK      = 3'd6;
    localparam logic [2:0] REJ_POOL     = 3'd7;

    localparam logic REC_TRADE  = 1'b0;
    localparam logic REC_RESULT = 1'b1;

    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_INSERT,
        CMD_SET_LEFT,
        CMD_CLEAR
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t            op;
        logic [IDX_W-1:0]   idx;
        logic [31:0]        ident;
        logic [15:0]        trader;
        logic               side;
        logic signed [31:0] price;
        logic [31:0]        left;
        logic [31:0]        arrival;
    } cmd_t;

    typedef struct packed {
        logic [31:0]        ident;
        logic               side;
        logic               market;
        logic signed [31:0] price;
    } query_t;

    typedef struct packed {
        logic                found;
        logic [IDX_W-1:0]    found_idx;
        logic [15:0]         found_trader;
        logic                found_side;
        logic signed [31:0]  found_price;
        logic [31:0]         found_left;
        logic                best_ok;
        logic [IDX_W-1:0]    best_idx;
        logic [31:0]         best_ident;
        logic [15:0]         best_trader;
        logic signed [31:0]  best_price;
        logic [31:0]         best_left;
        logic [31:0]         best_arr;
        logic [AVAIL_W-1:0]  avail;
        logic                free_ok;
        logic [IDX_W-1:0]    free_idx;
    } sweep_t;

    typedef struct packed {
        logic               kind;
        logic               last;
        logic [31:0]        ident;
        logic [15:0]        trader;
        logic signed [31:0] price;
        logic [31:0]        amount;
        logic [31:0]        left;
        logic [2:0]         state;
        logic [2:0]         code;
        logic               lp;
        logic [31:0]        seq;
        logic [63:0]        ts;
    } rec_t;

endpackage

/* src/lobm_cell.sv */
// ----------------------------------------------------------------------------
// lobm_cell
// One book slot. Folds its slot into the sweep beat passing down the chain.
// ----------------------------------------------------------------------------
module lobm_cell #(
    parameter int IDX = 0
) (
    input  logic             clk,
    input  logic             rst_n,
    input  lobm_pkg::cmd_t   cmd,
    input  lobm_pkg::query_t query,
    input  lobm_pkg::sweep_t sweep_in,
    output lobm_pkg::sweep_t sweep_out
);
    import lobm_pkg::*;

    logic               used_reg;
    logic [31:0]        ident_reg;
    logic [15:0]        trader_reg;
    logic               side_reg;
    logic signed [31:0] price_reg;
    logic [31:0]        left_reg;
    logic [31:0]        arr_reg;
    sweep_t             sweep_reg;
    sweep_t             sweep_next;
    logic               elig;
    logic               take;
    logic               hit;

    assign hit = (cmd.op != CMD_NONE) && (cmd.idx == IDX_W'(IDX));

    always_comb
    begin
        sweep_next = sweep_in;
        elig = used_reg && (side_reg != query.side) &&
               (query.market || (query.side == 1'b0 ? price_reg <= query.price
                                                     : price_reg >= query.price));
        if (!sweep_in.best_ok)
            take = 1'b1;
        else if (price_reg != sweep_in.best_price)
            take = (query.side == 1'b0) ? (price_reg < sweep_in.best_price)
                                        : (price_reg > sweep_in.best_price);
        else
            take = arr_reg < sweep_in.best_arr;

        if (used_reg && ident_reg == query.ident && !sweep_in.found)
        begin
            sweep_next.found        = 1'b1;
            sweep_next.found_idx    = IDX_W'(IDX);
            sweep_next.found_trader = trader_reg;
            sweep_next.found_side   = side_reg;
            sweep_next.found_price  = price_reg;
            sweep_next.found_left   = left_reg;
        end
        if (elig)
        begin
            sweep_next.avail = sweep_in.avail + AVAIL_W'(left_reg);
            if (take)
            begin
                sweep_next.best_ok     = 1'b1;
                sweep_next.best_idx    = IDX_W'(IDX);
                sweep_next.best_ident  = ident_reg;
                sweep_next.best_trader = trader_reg;
                sweep_next.best_price  = price_reg;
                sweep_next.best_left   = left_reg;
                sweep_next.best_arr    = arr_reg;
            end
        end
        if (!used_reg && !sweep_in.free_ok)
        begin
            sweep_next.free_ok  = 1'b1;
            sweep_next.free_idx = IDX_W'(IDX);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            used_reg <= 1'b0;
        else if (hit)
        begin
            case (cmd.op)
                CMD_INSERT:   used_reg <= 1'b1;
                CMD_SET_LEFT: if (cmd.left == 32'd0) used_reg <= 1'b0;
                CMD_CLEAR:    used_reg <= 1'b0;
                default:      used_reg <= used_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        sweep_reg <= sweep_next;
        if (hit && cmd.op == CMD_INSERT)
        begin
            ident_reg  <= cmd.ident;
            trader_reg <= cmd.trader;
            side_reg   <= cmd.side;
            price_reg  <= cmd.price;
            left_reg   <= cmd.left;
            arr_reg    <= cmd.arrival;
        end
        else if (hit && cmd.op == CMD_SET_LEFT)
            left_reg <= cmd.left;
    end

    assign sweep_out = sweep_reg;

endmodule

/* src/limit_order_book_matcher_unit.sv */
// ----------------------------------------------------------------------------
// limit_order_book_matcher_unit
// One-symbol price-time priority order book built as a chain of slot cells.
// ----------------------------------------------------------------------------
// Every request needs one sweep of the chain, plus one per trade and one after a
// re-queueing modify; each sweep ends in a decision state, which output stalls hold.
// A cancel or rejection loads its record after one sweep, an add with n fills
// after n + 1 sweeps.
// One request at a time; the next is taken once the final record is loaded.
// Reset clears the slot valid bits, the arrival counter and symbol_number.
module limit_order_book_matcher_unit #(
    parameter int MAX_ORDERS = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // order_number, trader_number, side, order_type, price, quantity,
    // tif, sequence_req, timestamp (lowest bit up), zero padded
    input  logic [215:0] s_tdata,
    input  logic [1:0]   s_tuser,   // kind
    output logic         m_tvalid,
    input  logic         m_tready,
    // ident, trader_out, trade_price, amount, left_over, final_state,
    // reject_code, requeued flag, seq_out, time_out (lowest bit up), padded
    output logic [247:0] m_tdata,
    output logic         m_tuser,   // record_kind
    output logic         m_tlast,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import lobm_pkg::*;

    localparam logic [CNT_W-1:0] SWEEP_END = CNT_W'(MAX_ORDERS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_CHECK,
        S_CHECK,
        S_SCAN_MATCH,
        S_MATCH
    } state_t;

    state_t             state_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [15:0]        symbol_reg;
    logic [31:0]        arrival_reg;
    cmd_t               cmd_reg;
    rec_t               out_reg;
    logic               out_valid_reg;

    logic [1:0]         kind_reg;
    logic [31:0]        id_reg;
    logic [15:0]        trader_reg;
    logic               side_reg;
    logic               market_reg;
    logic signed [31:0] price_reg;
    logic [31:0]        qty_reg;
    logic [1:0]         tif_reg;
    logic [31:0]        seq_reg;
    logic [63:0]        ts_reg;
    logic               lp_reg;
    logic [31:0]        remaining_reg;
    logic [31:0]        filled_reg;

    query_t             query;
    sweep_t             chain [MAX_ORDERS+1];
    sweep_t             res;
    logic               out_free;
    logic [2:0]         add_code;
    logic [31:0]        fill_q;

    assign query = '{ident: id_reg, side: side_reg, market: market_reg, price: price_reg};
    assign chain[0] = '0;
    assign res = chain[MAX_ORDERS];

    genvar g;
    generate
        for (g = 0; g < MAX_ORDERS; g++)
        begin : g_cell
            lobm_cell #(.IDX(g)) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .cmd       (cmd_reg),
                .query     (query),
                .sweep_in  (chain[g]),
                .sweep_out (chain[g+1])
            );
        end
    endgenerate

    assign out_free = !out_valid_reg || m_tready;
    assign fill_q   = (remaining_reg < res.best_left) ? remaining_reg : res.best_left;

    always_comb
    begin
        if (id_reg == 32'd0)
            add_code = REJ_UNKNOWN;
        else if (res.found)
            add_code = REJ_DUP;
        else if (qty_reg == 32'd0)
            add_code = REJ_BAD_QTY;
        else if (!market_reg && price_reg <= 32'sd0)
            add_code = REJ_BAD_PX;
        else if (market_reg && !res.best_ok)
            add_code = REJ_NO_LIQ;
        else if (tif_reg == TIF_FOK && res.avail < AVAIL_W'(qty_reg))
            add_code = REJ_FOK;
        else
            add_code = REJ_NONE;
    end

    function automatic rec_t mk_result(input logic [31:0] ident, input logic [15:0] trader,
                                       input logic [31:0] amount, input logic [31:0] left,
                                       input logic [2:0] st, input logic [2:0] code,
                                       input logic lp, input logic [31:0] seq,
                                       input logic [63:0] ts);
        rec_t r;
        r.kind   = REC_RESULT;
        r.last   = 1'b1;
        r.ident  = ident;
        r.trader = trader;
        r.price  = '0;
        r.amount = amount;
        r.left   = left;
        r.state  = st;
        r.code   = code;
        r.lp     = lp;
        r.seq    = seq;
        r.ts     = ts;
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            arrival_reg   <= '0;
            cmd_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_op_t op_next;
            logic    out_valid_next;
            op_next        = CMD_NONE;
            out_valid_next = out_valid_reg && !m_tready;
            case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        kind_reg      <= s_tuser;
                        id_reg        <= s_tdata[31:0];
                        trader_reg    <= s_tdata[47:32];
                        side_reg      <= s_tdata[48];
                        market_reg    <= s_tdata[49];
                        price_reg     <= s_tdata[81:50];
                        qty_reg       <= s_tdata[113:82];
                        remaining_reg <= s_tdata[113:82];
                        tif_reg       <= s_tdata[115:114];
                        seq_reg       <= s_tdata[147:116];
                        ts_reg        <= s_tdata[211:148];
                        lp_reg        <= 1'b0;
                        filled_reg    <= '0;
                        cnt_reg       <= '0;
                        if (s_tuser != KIND_NONE)
                            state_reg <= S_SCAN_CHECK;
                    end
                end
                S_SCAN_CHECK, S_SCAN_MATCH:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == SWEEP_END)
                        state_reg <= (state_reg == S_SCAN_CHECK) ? S_CHECK : S_MATCH;
                end
                S_CHECK:
                begin
                    if (out_free)
                    begin
                        case (kind_reg)
                            KIND_CANCEL:
                            begin
                                out_valid_next = 1'b1;
                                state_reg     <= S_IDLE;
                                if (!res.found)
                                    out_reg <= mk_result(id_reg, '0, '0, '0, ST_REJECTED,
                                                         REJ_UNKNOWN, 1'b0, seq_reg, ts_reg);
                                else
                                begin
                                    out_reg <= mk_result(id_reg, res.found_trader, '0, '0,
                                                         ST_CANCELLED, REJ_NONE, 1'b0,
                                                         seq_reg, ts_reg);
                                    op_next      = CMD_CLEAR;
                                    cmd_reg.idx <= res.found_idx;
                                end
                            end
                            KIND_MODIFY:
                            begin
                                if (!res.found || qty_reg == 32'd0 || price_reg <= 32'sd0)
                                begin
                                    out_valid_next = 1'b1;
                                    state_reg     <= S_IDLE;
                                    out_reg <= mk_result(id_reg, '0, '0, '0, ST_REJECTED,
                                                         !res.found ? REJ_UNKNOWN :
                                                         (qty_reg == 32'd0) ? REJ_BAD_QTY :
                                                         REJ_BAD_PX, 1'b0, seq_reg, ts_reg);
                                end
                                else if (price_reg == res.found_price &&
                                         qty_reg <= res.found_left)
                                begin
                                    out_valid_next = 1'b1;
                                    state_reg     <= S_IDLE;
                                    out_reg <= mk_result(id_reg, '0, '0, qty_reg, ST_PARTIAL,
                                                         REJ_NONE, 1'b0, seq_reg, ts_reg);
                                    op_next       = CMD_SET_LEFT;
                                    cmd_reg.idx  <= res.found_idx;
                                    cmd_reg.left <= qty_reg;
                                end
                                else
                                begin
                                    // pull the order and re-enter it as a limit GTC add
                                    op_next      = CMD_CLEAR;
                                    cmd_reg.idx <= res.found_idx;
                                    trader_reg  <= res.found_trader;
                                    side_reg    <= res.found_side;
                                    market_reg  <= 1'b0;
                                    tif_reg     <= TIF_GTC;
                                    lp_reg      <= 1'b1;
                                    cnt_reg     <= '0;
                                    state_reg   <= S_SCAN_MATCH;
                                end
                            end
                            default:
                            begin
                                if (add_code != REJ_NONE)
                                begin
                                    out_valid_next = 1'b1;
                                    state_reg     <= S_IDLE;
                                    out_reg <= mk_result(id_reg, '0, '0, '0, ST_REJECTED,
                                                         add_code, 1'b0, seq_reg, ts_reg);
                                end
                                else
                                    state_reg <= S_MATCH;
                            end
                        endcase
                    end
                end
                S_MATCH:
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        if (remaining_reg != 32'd0 && res.best_ok)
                        begin
                            out_reg.kind   <= REC_TRADE;
                            out_reg.last   <= 1'b0;
                            out_reg.ident  <= res.best_ident;
                            out_reg.trader <= res.best_trader;
                            out_reg.price  <= res.best_price;
                            out_reg.amount <= fill_q;
                            out_reg.left   <= res.best_left - fill_q;
                            out_reg.state  <= (res.best_left == fill_q) ? ST_FILLED
                                                                        : ST_PARTIAL;
                            out_reg.code   <= REJ_NONE;
                            out_reg.lp     <= 1'b0;
                            out_reg.seq    <= seq_reg;
                            out_reg.ts     <= ts_reg;
                            op_next         = CMD_SET_LEFT;
                            cmd_reg.idx    <= res.best_idx;
                            cmd_reg.left   <= res.best_left - fill_q;
                            remaining_reg  <= remaining_reg - fill_q;
                            filled_reg     <= filled_reg + fill_q;
                            cnt_reg        <= '0;
                            state_reg      <= S_SCAN_MATCH;
                        end
                        else if (!market_reg && tif_reg == TIF_GTC && remaining_reg != 32'd0)
                        begin
                            state_reg <= S_IDLE;
                            if (res.free_ok)
                            begin
                                out_reg <= mk_result(id_reg, '0, filled_reg, remaining_reg,
                                                     (filled_reg != 32'd0) ? ST_PARTIAL
                                                                           : ST_NEW,
                                                     REJ_NONE, lp_reg, seq_reg, ts_reg);
                                op_next          = CMD_INSERT;
                                cmd_reg.idx     <= res.free_idx;
                                cmd_reg.ident   <= id_reg;
                                cmd_reg.trader  <= trader_reg;
                                cmd_reg.side    <= side_reg;
                                cmd_reg.price   <= price_reg;
                                cmd_reg.left    <= remaining_reg;
                                cmd_reg.arrival <= arrival_reg;
                                arrival_reg     <= arrival_reg + 1'b1;
                            end
                            else
                                out_reg <= mk_result(id_reg, '0, filled_reg, '0,
                                                     (filled_reg != 32'd0) ? ST_FILLED
                                                                           : ST_REJECTED,
                                                     REJ_POOL, lp_reg, seq_reg, ts_reg);
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                            out_reg <= mk_result(id_reg, '0, filled_reg, '0,
                                                 (remaining_reg == 32'd0) ? ST_FILLED
                                                                          : ST_CANCELLED,
                                                 REJ_NONE, lp_reg, seq_reg, ts_reg);
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
            cmd_reg.op    <= op_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            symbol_reg <= '0;
        else if (psel && penable && pwrite && paddr == 3'd0)
            symbol_reg <= pwdata[15:0];
    end

    assign pready = 1'b1;
    assign prdata = (paddr == 3'd0) ? {16'd0, symbol_reg} : 32'd0;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.last;
    assign m_tdata  = {1'b0, out_reg.ts, out_reg.seq, out_reg.lp, out_reg.code,
                       out_reg.state, out_reg.left, out_reg.amount, out_reg.price,
                       out_reg.trader, out_reg.ident};

endmodule
